// ===== src/hiad_pkg.sv =====
package hiad_pkg;

    // Sizes of the sample store and the packet offset counter.
    localparam int SAMPLE_DEPTH     = 1024;
    localparam int MAX_PACKET_BYTES = 2048;

    localparam int IDX_W = $clog2(SAMPLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int POS_W = $clog2(MAX_PACKET_BYTES);

    // Field widths of the channels.
    localparam int BYTE_W         = 8;
    localparam int SAMPLE_W       = 16;
    localparam int WORD_W         = 2 * SAMPLE_W;
    localparam int SAMPLE_INDEX_W = 10;
    localparam int HDR_W          = 6;
    localparam int PKT_W          = 4;
    localparam int ACC_W          = 12;
    localparam int DIGIT_CNT_W    = 2;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;

    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_BYTES  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REAL_PACKETS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_PACKETS = 2'd2;

    localparam logic [HDR_W-1:0] HEADER_BYTES_RESET  = 6'd14;
    localparam logic [PKT_W-1:0] REAL_PACKETS_RESET  = 4'd4;
    localparam logic [PKT_W-1:0] TOTAL_PACKETS_RESET = 4'd8;

    localparam logic [BYTE_W-1:0] ASCII_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] LETTER_BASE   = 8'd10;

    localparam logic [DIGIT_CNT_W-1:0] LAST_DIGIT = 2'd3;

    typedef struct packed {
        logic [HDR_W-1:0] header_bytes;
        logic [PKT_W-1:0] real_packets;
        logic [PKT_W-1:0] total_packets;
    } hiad_cfg_t;

    // One decoded sample and what the store has to do with it.
    typedef struct packed {
        logic                      real_wr;
        logic                      imag_rd;
        logic                      imag_has_real;
        logic [SAMPLE_W-1:0]       sample;
        logic [IDX_W-1:0]          real_addr;
        logic [IDX_W-1:0]          imag_addr;
        logic [SAMPLE_INDEX_W-1:0] imag_index;
    } hiad_evt_t;

    // Decimal digits map directly; any other byte is taken as a letter, modulo 16.
    function automatic logic [3:0] nibble_of(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        begin
            if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
                v = c - ASCII_ZERO;
            end else begin
                v = c - ASCII_UPPER_A + LETTER_BASE;
            end
            return v[3:0];
        end
    endfunction

endpackage

// ===== src/hiad_parse.sv =====
module hiad_parse
    import hiad_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_accept,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              last_byte,
    input  hiad_cfg_t         cfg,
    output hiad_evt_t         evt
);

    logic [POS_W-1:0]       byte_pos_reg,     byte_pos_next;
    logic [PKT_W-1:0]       packet_count_reg, packet_count_next;
    logic [ACC_W-1:0]       digit_acc_reg,    digit_acc_next;
    logic [DIGIT_CNT_W-1:0] digit_cnt_reg,    digit_cnt_next;
    logic [CNT_W-1:0]       real_idx_reg,     real_idx_next;
    logic [CNT_W-1:0]       imag_idx_reg,     imag_idx_next;

    logic       in_payload;
    logic       complete;
    logic       pkt_real;
    logic       pkt_imag;
    logic       real_room;
    logic       imag_room;
    logic [3:0] digit;

    always_comb begin
        in_payload = byte_pos_reg >= POS_W'(cfg.header_bytes);
        digit      = nibble_of(data_byte);
        complete   = in_payload && (digit_cnt_reg == LAST_DIGIT);
        pkt_real   = packet_count_reg < cfg.real_packets;
        pkt_imag   = !pkt_real && (packet_count_reg < cfg.total_packets);
        real_room  = real_idx_reg < CNT_W'(SAMPLE_DEPTH);
        imag_room  = imag_idx_reg < CNT_W'(SAMPLE_DEPTH);

        evt.real_wr       = byte_accept && complete && pkt_real && real_room;
        evt.imag_rd       = byte_accept && complete && pkt_imag && imag_room;
        evt.sample        = {digit_acc_reg, digit};
        evt.real_addr     = real_idx_reg[IDX_W-1:0];
        evt.imag_addr     = imag_idx_reg[IDX_W-1:0];
        // Entries at or beyond the fill count were never written; the result uses zero for them.
        evt.imag_has_real = imag_idx_reg < real_idx_reg;
        evt.imag_index    = SAMPLE_INDEX_W'(imag_idx_reg);
    end

    always_comb begin
        byte_pos_next     = byte_pos_reg;
        packet_count_next = packet_count_reg;
        digit_acc_next    = digit_acc_reg;
        digit_cnt_next    = digit_cnt_reg;
        real_idx_next     = real_idx_reg;
        imag_idx_next     = imag_idx_reg;

        if (byte_accept) begin
            if (in_payload) begin
                if (complete) begin
                    digit_acc_next = '0;
                    digit_cnt_next = '0;
                end else begin
                    digit_acc_next = {digit_acc_reg[ACC_W-5:0], digit};
                    digit_cnt_next = digit_cnt_reg + 1'b1;
                end
            end
            if (evt.real_wr) begin
                real_idx_next = real_idx_reg + 1'b1;
            end
            if (evt.imag_rd) begin
                imag_idx_next = imag_idx_reg + 1'b1;
            end
            if (byte_pos_reg < POS_W'(MAX_PACKET_BYTES - 1)) begin
                byte_pos_next = byte_pos_reg + 1'b1;
            end
            // End of packet drops any partial group and advances the packet count.
            if (last_byte) begin
                byte_pos_next  = '0;
                digit_acc_next = '0;
                digit_cnt_next = '0;
                if (packet_count_reg != '1) begin
                    packet_count_next = packet_count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg     <= '0;
            packet_count_reg <= '0;
            digit_acc_reg    <= '0;
            digit_cnt_reg    <= '0;
            real_idx_reg     <= '0;
            imag_idx_reg     <= '0;
        end else begin
            byte_pos_reg     <= byte_pos_next;
            packet_count_reg <= packet_count_next;
            digit_acc_reg    <= digit_acc_next;
            digit_cnt_reg    <= digit_cnt_next;
            real_idx_reg     <= real_idx_next;
            imag_idx_reg     <= imag_idx_next;
        end
    end

endmodule

// ===== src/hex_ascii_iq_deframer.sv =====
// Hex ASCII I/Q deframer.
// The s_ channel takes packet bytes, one request per byte, with s_last_byte
// set on the final byte of each packet. The first header_bytes bytes of each
// packet are skipped; the rest is read as groups of four hex characters, most
// significant first, each group giving one 16-bit sample. Samples of the first
// real_packets packets are written into a 1024-entry sample memory. Each sample
// of the following packets, up to packet total_packets, is an imaginary sample
// and leaves on the m_ channel as one request: imaginary part in bits 31:16 and
// the real sample of the same index in bits 15:0, with that index.
// Throughput is one byte per cycle while s_ready is high, with at most one
// memory access per byte. When the byte that completes a group is accepted,
// the memory read and the read stage register it; the output register loads
// from the read stage once it is free or drained, and drives m_valid.
// The cfg_ channel writes header_bytes, real_packets and total_packets by index;
// it is always ready and should be used only while no byte is in flight.
// Reset clears all counters, the pipeline and the configuration to 14, 4 and 8.
// The memory needs no clearing pass: a fill count marks which entries were
// written, and an entry that was not written reads as zero.
// When m_ready is low, the output register and one more result in the read
// stage are held; s_ready drops only once both are occupied.
module hex_ascii_iq_deframer
    import hiad_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [BYTE_W-1:0]         s_data_byte,
    input  logic                      s_last_byte,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [WORD_W-1:0]         m_packed_word,
    output logic [SAMPLE_INDEX_W-1:0] m_sample_index,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    hiad_cfg_t cfg_reg, cfg_next;
    hiad_evt_t evt;

    logic s_accept;
    logic p1_move;

    // Sample memory with a registered read port.
    logic [SAMPLE_W-1:0] real_store_mem [SAMPLE_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    // Read stage: waits for the memory data.
    logic                      p1_valid_reg, p1_valid_next;
    logic [SAMPLE_W-1:0]       p1_sample_reg;
    logic [SAMPLE_INDEX_W-1:0] p1_index_reg;
    logic                      p1_has_real_reg;

    // Output register.
    logic                      m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]         m_packed_reg;
    logic [SAMPLE_INDEX_W-1:0] m_index_reg;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_HEADER_BYTES:  cfg_next.header_bytes  = cfg_data[HDR_W-1:0];
                CFG_REAL_PACKETS:  cfg_next.real_packets  = cfg_data[PKT_W-1:0];
                CFG_TOTAL_PACKETS: cfg_next.total_packets = cfg_data[PKT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // The read stage advances whenever the output register is free or drained.
    assign p1_move  = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !p1_valid_reg || p1_move;
    assign s_accept = s_valid && s_ready;

    hiad_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (s_accept),
        .data_byte   (s_data_byte),
        .last_byte   (s_last_byte),
        .cfg         (cfg_reg),
        .evt         (evt)
    );

    // A byte writes the memory or reads it, never both, so no forwarding is
    // needed. A later write to an entry already read cannot disturb that read.
    always_ff @(posedge aclk) begin
        if (evt.real_wr) begin
            real_store_mem[evt.real_addr] <= evt.sample;
        end
        if (evt.imag_rd) begin
            rd_data_reg <= real_store_mem[evt.imag_addr];
        end
    end

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (s_accept) begin
            p1_valid_next = evt.imag_rd;
        end else if (p1_move) begin
            p1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (p1_move) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_bytes  <= HEADER_BYTES_RESET;
            cfg_reg.real_packets  <= REAL_PACKETS_RESET;
            cfg_reg.total_packets <= TOTAL_PACKETS_RESET;
            p1_valid_reg          <= 1'b0;
            m_valid_reg           <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (evt.imag_rd) begin
            p1_sample_reg   <= evt.sample;
            p1_index_reg    <= evt.imag_index;
            p1_has_real_reg <= evt.imag_has_real;
        end
        if (p1_move) begin
            m_packed_reg <= {p1_sample_reg, p1_has_real_reg ? rd_data_reg : SAMPLE_W'(0)};
            m_index_reg  <= p1_index_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_packed_word  = m_packed_reg;
    assign m_sample_index = m_index_reg;

endmodule

// ===== src/hiad_checker.sv =====
module hiad_checker
    import hiad_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [WORD_W-1:0]         m_packed_word,
    input logic [SAMPLE_INDEX_W-1:0] m_sample_index
);

    // Results leave in index order starting from zero after reset.
    logic [SAMPLE_INDEX_W-1:0] exp_index_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_index_reg <= '0;
        end else if (m_valid && m_ready) begin
            exp_index_reg <= exp_index_reg + 1'b1;
        end
    end

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_index_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_sample_index == exp_index_reg)
        else $error("result index out of order");

    a_ready_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while the result side drains");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_packed_word)
                                && $stable(m_sample_index))
        else $error("stalled result changed");

endmodule

bind hex_ascii_iq_deframer hiad_checker u_checker (.*);
